### src/chte_pkg.sv
// Shared types and constants for the chained hash table engine.
package chte_pkg;

  localparam int KIND_W = 2;
  localparam int KEY_W  = 64;
  localparam int SLOT_W = 10;
  localparam int CFG_W  = 11;

  localparam logic [KEY_W-1:0] HASH_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_KEYWAIT,
    S_HASH,
    S_HEADWAIT,
    S_WALK,
    S_NODEWAIT,
    S_UNLINK,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_DIV
  } hash_state_t;

endpackage

### src/chte_req_if.sv
// Request channel: operation kind, key and node slot.
interface chte_req_if import chte_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, kind, key, slot, input ready);
  modport sink   (input valid, kind, key, slot, output ready);
endinterface

### src/chte_rsp_if.sv
// Response channel: found flag and matching slot.
interface chte_rsp_if import chte_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] match_slot;

  modport source (output valid, found, match_slot, input ready);
  modport sink   (input valid, found, match_slot, output ready);
endinterface

### src/chte_hash.sv
// Multiplicative hash with a shared 32x32 multiplier and a radix-16 remainder unit.
module chte_hash import chte_pkg::*; #(
  parameter int CNT_W = 11,
  parameter int BIW   = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] modulus,
  output logic             done,
  output logic [BIW-1:0]   bucket
);

  hash_state_t      hstate;
  hash_state_t      hstate_next;
  logic [1:0]       ph;
  logic [3:0]       dcnt;
  logic [KEY_W-1:0] key_r;
  logic [63:0]      prod;
  logic [63:0]      acc;
  logic [63:0]      acc_next;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_next;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;

  always_comb begin
    case (ph)
      2'd0: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL[31:0];
      end
      2'd1: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL[63:32];
      end
      default: begin
        mul_a = key_r[63:32];
        mul_b = HASH_MUL[31:0];
      end
    endcase
  end

  // four restoring steps per cycle, dividend shifts out of acc msb first
  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    logic [63:0]      a;
    r = rem;
    a = acc;
    for (int i = 0; i < 4; i++) begin
      t = {r, a[63]};
      a = {a[62:0], 1'b0};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      r = t[CNT_W-1:0];
    end
    rem_next = r;
    acc_next = a;
  end

  always_comb begin
    hstate_next = hstate;
    case (hstate)
      H_IDLE: if (start) hstate_next = H_MUL;
      H_MUL:  if (ph == 2'd3) hstate_next = H_DIV;
      H_DIV:  if (dcnt == 4'd15) hstate_next = H_IDLE;
      default: hstate_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      hstate <= hstate_next;
      done   <= (hstate == H_DIV) && (dcnt == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    case (hstate)
      H_IDLE: begin
        if (start) begin
          key_r <= key;
          ph    <= 2'd0;
        end
      end
      H_MUL: begin
        prod <= {32'b0, mul_a} * {32'b0, mul_b};
        ph   <= ph + 2'd1;
        if (ph == 2'd1) begin
          acc <= prod;
        end else if (ph != 2'd0) begin
          acc[63:32] <= acc[63:32] + prod[31:0];
        end
        rem  <= '0;
        dcnt <= 4'd0;
      end
      H_DIV: begin
        rem  <= rem_next;
        acc  <= acc_next;
        dcnt <= dcnt + 4'd1;
      end
      default: ;
    endcase
  end

  assign bucket = BIW'(rem);

endmodule

### src/chained_hash_table_engine.sv
// Insert stores the key and links the slot in at the bucket head; find walks the chain until
// a key matches or the chain ends; remove hashes the key stored in the slot, walks to the slot
// and unlinks it. Hashing uses the shared 32x32 multiplier, the remainder unit, then flags done.
// One operation is in work at a time; the next request is taken the cycle after the response
// loads, and an untaken response holds the engine. After reset the bucket heads are cleared,
// one per cycle, before the first request is taken; bucket count resets to 1024.
module chained_hash_table_engine import chte_pkg::*; #(
  parameter int MAX_BUCKETS = 1024,
  parameter int NODE_SLOTS  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  chte_req_if.sink         req,
  chte_rsp_if.source       rsp
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int BIW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW    = $clog2(NODE_SLOTS);
  localparam int STW   = $clog2(NODE_SLOTS + 1);

  // bucket heads and links carry a valid flag in the top bit
  logic [NW:0]      head_mem [MAX_BUCKETS];
  logic [KEY_W-1:0] key_mem  [NODE_SLOTS];
  logic [NW:0]      next_mem [NODE_SLOTS];

  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [CFG_W-1:0] nbuckets;
  logic [CNT_W-1:0] modulus;
  logic [BIW-1:0]   clr_cnt;

  logic [KIND_W-1:0] op_kind;
  logic [KEY_W-1:0]  key_r;
  logic [NW-1:0]     sidx;
  logic [NW-1:0]     req_idx;
  logic              req_slot_ok;
  logic [BIW-1:0]    bucket_r;
  logic [NW-1:0]     cur;
  logic              ok;
  logic [STW-1:0]    steps;
  logic [NW-1:0]     prev;
  logic              have_prev;
  logic              res_found;
  logic [SLOT_W-1:0] res_match;
  logic [31:0]       cur_wide;

  logic              head_we;
  logic [BIW-1:0]    head_wa;
  logic [NW:0]       head_wd;
  logic [BIW-1:0]    head_ra;
  logic [NW:0]       head_q;
  logic              key_we;
  logic              next_we;
  logic [NW-1:0]     next_wa;
  logic [NW:0]       next_wd;
  logic [NW-1:0]     node_ra;
  logic [KEY_W-1:0]  key_q;
  logic [NW:0]       next_q;

  logic              hash_start;
  logic [KEY_W-1:0]  hash_key;
  logic              hash_done;
  logic [BIW-1:0]    hash_bucket;
  logic              walk_go;

  logic              out_valid;
  logic              out_found;
  logic [SLOT_W-1:0] out_match;

  chte_hash #(.CNT_W(CNT_W), .BIW(BIW)) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key     (hash_key),
    .modulus (modulus),
    .done    (hash_done),
    .bucket  (hash_bucket)
  );

  always_comb begin
    if (nbuckets == '0) begin
      modulus = CNT_W'(1);
    end else if (32'(nbuckets) > MAX_BUCKETS) begin
      modulus = CNT_W'(MAX_BUCKETS);
    end else begin
      modulus = CNT_W'(nbuckets);
    end
  end

  assign req_idx     = NW'(req.slot);
  assign req_slot_ok = 32'(req.slot) < NODE_SLOTS;
  assign cur_wide    = 32'(cur);
  assign walk_go     = ok && (32'(steps) < NODE_SLOTS) && (cur_wide < NODE_SLOTS);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[req_idx] <= req.key;
    end
    key_q <= key_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_q <= next_mem[node_ra];
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    head_we    = 1'b0;
    head_wa    = bucket_r;
    head_wd    = next_q;
    head_ra    = hash_bucket;
    key_we     = 1'b0;
    next_we    = 1'b0;
    next_wa    = sidx;
    next_wd    = head_q;
    node_ra    = cur;
    hash_start = 1'b0;
    hash_key   = req.key;
    case (state)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_cnt;
        head_wd = '0;
        if (32'(clr_cnt) == MAX_BUCKETS - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        node_ra   = req_idx;
        if (req.valid) begin
          case (req.kind)
            KIND_FIND: begin
              hash_start = 1'b1;
              state_next = S_HASH;
            end
            KIND_INSERT: begin
              if (req_slot_ok) begin
                key_we     = 1'b1;
                hash_start = 1'b1;
                state_next = S_HASH;
              end else begin
                state_next = S_DONE;
              end
            end
            KIND_REMOVE: begin
              state_next = req_slot_ok ? S_KEYWAIT : S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_KEYWAIT: begin
        hash_key   = key_q;
        hash_start = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: begin
        if (hash_done) state_next = S_HEADWAIT;
      end
      S_HEADWAIT: begin
        if (op_kind == KIND_INSERT) begin
          next_we    = 1'b1;
          head_we    = 1'b1;
          head_wd    = {1'b1, sidx};
          state_next = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        state_next = walk_go ? S_NODEWAIT : S_DONE;
      end
      S_NODEWAIT: begin
        if (op_kind == KIND_FIND) begin
          state_next = (key_q == key_r) ? S_DONE : S_WALK;
        end else if (cur == sidx) begin
          // splice the successor into the predecessor or the bucket head
          if (have_prev) begin
            next_we = 1'b1;
            next_wa = prev;
            next_wd = next_q;
          end else begin
            head_we = 1'b1;
          end
          state_next = S_UNLINK;
        end else begin
          state_next = S_WALK;
        end
      end
      S_UNLINK: begin
        next_we    = 1'b1;
        next_wd    = '0;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      nbuckets  <= BUCKET_COUNT_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + BIW'(1);
      if (cfg_we) nbuckets <= cfg_data;
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_kind   <= req.kind;
        key_r     <= req.key;
        sidx      <= req_idx;
        res_found <= 1'b0;
        res_match <= '0;
      end
      S_HASH: begin
        if (hash_done) bucket_r <= hash_bucket;
      end
      S_HEADWAIT: begin
        ok        <= head_q[NW];
        cur       <= head_q[NW-1:0];
        steps     <= '0;
        have_prev <= 1'b0;
      end
      S_NODEWAIT: begin
        if (op_kind == KIND_FIND && key_q == key_r) begin
          res_found <= 1'b1;
          res_match <= cur_wide[SLOT_W-1:0];
        end else if (op_kind != KIND_FIND && cur == sidx) begin
          res_found <= 1'b1;
        end
        prev      <= cur;
        have_prev <= 1'b1;
        ok        <= next_q[NW];
        cur       <= next_q[NW-1:0];
        steps     <= steps + STW'(1);
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_found <= res_found;
          out_match <= res_match;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.match_slot = out_match;

endmodule
